// File: src/nsr_pkg.sv
// nsr_pkg: request and response beat types and op and status codes, shared by
// the registry and its checker, and the name normalization of the registry.
// No dependencies.
package nsr_pkg;

  localparam int NAME_W  = 256;
  localparam int ID_W    = 32;
  localparam int ENTRY_W = NAME_W + ID_W;

  // a snapshot never returns more than this many entries
  localparam logic [5:0] RESULT_CAP = 6'd32;

  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_LOOKUP     = 2'd2,
    OP_SNAPSHOT   = 2'd3
  } nsr_op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_NOSPACE  = 2'd2,
    ST_NOTFOUND = 2'd3
  } nsr_status_t;

  typedef struct packed {
    nsr_op_t     req_type;
    logic [63:0] name_w0;
    logic [63:0] name_w1;
    logic [63:0] name_w2;
    logic [63:0] name_w3;
    logic [31:0] service_id;
    logic [5:0]  limit;
  } nsr_req_t;

  typedef struct packed {
    nsr_status_t status;
    logic [31:0] found_id;
    logic [63:0] out_w0;
    logic [63:0] out_w1;
    logic [63:0] out_w2;
    logic [63:0] out_w3;
    logic        entry_valid;
    logic [5:0]  entry_count;
    logic        last;
  } nsr_rsp_t;

  // force the final byte to zero and clear every byte after the first zero
  function automatic logic [NAME_W-1:0] nsr_normalize(input logic [63:0] w0,
                                                      input logic [63:0] w1,
                                                      input logic [63:0] w2,
                                                      input logic [63:0] w3);
    logic [NAME_W-1:0] raw;
    logic [NAME_W-1:0] nm;
    logic              ended;
    logic [7:0]        b;
    raw   = {w3, w2, w1, w0};
    nm    = '0;
    ended = 1'b0;
    for (int i = 0; i < NAME_W / 8; i++) begin
      b = raw[8*i +: 8];
      if (i == NAME_W / 8 - 1 || ended) begin
        b = 8'd0;
      end
      if (b == 8'd0) begin
        ended = 1'b1;
      end
      nm[8*i +: 8] = b;
    end
    return nm;
  endfunction

endpackage

// File: src/named_service_registry_unit.sv
// named_service_registry_unit: ordered table of (name, service id) entries
// with register, unregister, lookup and snapshot requests.
// Depends on nsr_pkg and nsr_store.

// A request is taken when start is high and busy is low. Unless it is answered
// directly, busy then stays high until the request's final result is issued.
// Results come out as beats on out_valid, one cycle each, and must be taken at
// once since there is no backpressure. Every request that is not answered
// directly walks the table through the single read port of the entry memory,
// one row per cycle. A register with an empty name or a bad id, an unregister
// with an empty name, and a snapshot with nothing to return, are answered
// directly, in the cycle after they are taken. Register, unregister and lookup
// compare against each stored row in turn, stopping at the first hit.
// Unregister then moves every later row down one place. A snapshot issues its
// entries back to back, each from the registered read of its row.
module named_service_registry_unit
  import nsr_pkg::*;
#(
  parameter int MAX_SERVICES = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  nsr_req_t in_req,
  output logic     out_valid,
  output nsr_rsp_t out_rsp
);

  localparam int CW = $clog2(MAX_SERVICES + 1);
  localparam int AW = (MAX_SERVICES > 1) ? $clog2(MAX_SERVICES) : 1;
  localparam int XW = (CW > 6) ? CW : 6;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_SNAP} state_t;

  state_t            state_r, state_nxt;
  nsr_op_t           op_r, op_nxt;
  logic [NAME_W-1:0] name_r, name_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [ID_W-1:0]   found_r, found_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic              cmp_v_r, cmp_v_nxt;
  logic              out_valid_r, out_valid_nxt;
  nsr_rsp_t          out_rsp_r, out_rsp_nxt;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;
  logic [NAME_W-1:0]  rd_name;
  logic [ID_W-1:0]    rd_id;

  logic [NAME_W-1:0] in_name;
  logic              in_empty;
  logic              in_bad_id;
  logic [5:0]        lim_c;
  logic [XW-1:0]     cnt_x, lim_x, n_x;
  logic [CW-1:0]     snap_n;
  logic              scan_hit, scan_miss, full;

  function automatic logic [5:0] cnt6(input logic [CW-1:0] v);
    logic [CW+5:0] e;
    e = {6'd0, v};
    return e[5:0];
  endfunction

  function automatic nsr_rsp_t mk_rsp(input nsr_status_t st, input logic [ID_W-1:0] fid,
                                      input logic [NAME_W-1:0] nm, input logic ev,
                                      input logic [5:0] ec, input logic lst);
    nsr_rsp_t r;
    r.status      = st;
    r.found_id    = fid;
    r.out_w0      = nm[63:0];
    r.out_w1      = nm[127:64];
    r.out_w2      = nm[191:128];
    r.out_w3      = nm[255:192];
    r.entry_valid = ev;
    r.entry_count = ec;
    r.last        = lst;
    return r;
  endfunction

  nsr_store #(
    .DEPTH (MAX_SERVICES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  assign rd_name = mem_rdata[ENTRY_W-1:ID_W];
  assign rd_id   = mem_rdata[ID_W-1:0];

  assign in_name   = nsr_normalize(in_req.name_w0, in_req.name_w1,
                                   in_req.name_w2, in_req.name_w3);
  assign in_empty  = (in_name[7:0] == 8'd0);
  assign in_bad_id = (in_req.service_id == '0) || (in_req.service_id == '1);

  // snapshot length: min(count, limit, cap)
  assign lim_c  = (in_req.limit > RESULT_CAP) ? RESULT_CAP : in_req.limit;
  assign cnt_x  = XW'(cnt_r);
  assign lim_x  = XW'(lim_c);
  assign n_x    = (cnt_x < lim_x) ? cnt_x : lim_x;
  assign snap_n = n_x[CW-1:0];

  assign scan_hit  = cmp_v_r && (rd_name == name_r);
  assign scan_miss = !cmp_v_r && (idx_r >= cnt_r);
  assign full      = (cnt_r == CW'(MAX_SERVICES));

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    name_nxt      = name_r;
    id_nxt        = id_r;
    found_nxt     = found_r;
    n_nxt         = n_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_v_nxt     = cmp_v_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r[AW-1:0];
    mem_wdata     = {name_r, id_r};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_req.req_type;
          name_nxt  = in_name;
          id_nxt    = in_req.service_id;
          n_nxt     = snap_n;
          idx_nxt   = '0;
          cmp_v_nxt = 1'b0;
          unique case (in_req.req_type)
            OP_REGISTER: begin
              if (in_empty || in_bad_id) begin
                out_valid_nxt = 1'b1;
                out_rsp_nxt   = mk_rsp(ST_INVALID, '0, '0, 1'b0, cnt6(cnt_r), 1'b1);
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_UNREGISTER: begin
              if (in_empty) begin
                out_valid_nxt = 1'b1;
                out_rsp_nxt   = mk_rsp(ST_INVALID, '0, '0, 1'b0, cnt6(cnt_r), 1'b1);
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_LOOKUP: begin
              state_nxt = S_SCAN;
            end
            OP_SNAPSHOT: begin
              if (snap_n == '0) begin
                out_valid_nxt = 1'b1;
                out_rsp_nxt   = mk_rsp(ST_OK, '0, '0, 1'b0, cnt6(cnt_r), 1'b1);
              end else begin
                state_nxt = S_SNAP;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        priority if (scan_hit) begin
          unique case (op_r)
            OP_REGISTER: begin
              state_nxt     = S_IDLE;
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = mk_rsp(ST_INVALID, '0, '0, 1'b0, cnt6(cnt_r), 1'b1);
            end
            OP_UNREGISTER: begin
              // close the gap from the row after the hit onward
              state_nxt = S_SHIFT;
              found_nxt = rd_id;
              idx_nxt   = cmp_idx_r + CW'(1);
              cmp_v_nxt = 1'b0;
            end
            OP_LOOKUP: begin
              state_nxt     = S_IDLE;
              out_valid_nxt = 1'b1;
              out_rsp_nxt   = mk_rsp(ST_OK, rd_id, '0, 1'b0, cnt6(cnt_r), 1'b1);
            end
            OP_SNAPSHOT: begin
              state_nxt = S_IDLE;
            end
          endcase
        end else if (scan_miss) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          unique case (op_r)
            OP_REGISTER: begin
              if (full) begin
                out_rsp_nxt = mk_rsp(ST_NOSPACE, '0, '0, 1'b0, cnt6(cnt_r), 1'b1);
              end else begin
                mem_we      = 1'b1;
                cnt_nxt     = cnt_r + CW'(1);
                out_rsp_nxt = mk_rsp(ST_OK, '0, '0, 1'b0, cnt6(cnt_r + CW'(1)), 1'b1);
              end
            end
            OP_UNREGISTER: begin
              out_rsp_nxt = mk_rsp(ST_INVALID, '0, '0, 1'b0, cnt6(cnt_r), 1'b1);
            end
            OP_LOOKUP: begin
              out_rsp_nxt = mk_rsp(ST_NOTFOUND, '0, '0, 1'b0, cnt6(cnt_r), 1'b1);
            end
            OP_SNAPSHOT: begin
              out_valid_nxt = 1'b0;
            end
          endcase
        end else if (idx_r < cnt_r) begin
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = idx_r;
          idx_nxt     = idx_r + CW'(1);
        end else begin
          cmp_v_nxt = 1'b0;
        end
      end

      S_SHIFT: begin
        // row read last cycle lands one place lower
        if (cmp_v_r) begin
          mem_we    = 1'b1;
          mem_waddr = cmp_idx_r[AW-1:0];
          mem_wdata = mem_rdata;
        end
        if (idx_r < cnt_r) begin
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = idx_r - CW'(1);
          idx_nxt     = idx_r + CW'(1);
        end else begin
          cmp_v_nxt = 1'b0;
          if (!cmp_v_r) begin
            state_nxt     = S_IDLE;
            cnt_nxt       = cnt_r - CW'(1);
            out_valid_nxt = 1'b1;
            out_rsp_nxt   = mk_rsp(ST_OK, found_r, '0, 1'b0, cnt6(cnt_r - CW'(1)), 1'b1);
          end
        end
      end

      S_SNAP: begin
        if (cmp_v_r) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = mk_rsp(ST_OK, rd_id, rd_name, 1'b1, cnt6(cnt_r),
                                 (cmp_idx_r + CW'(1)) == n_r);
          if ((cmp_idx_r + CW'(1)) == n_r) begin
            state_nxt = S_IDLE;
          end
        end
        if (idx_r < n_r) begin
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = idx_r;
          idx_nxt     = idx_r + CW'(1);
        end else begin
          cmp_v_nxt = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cmp_v_r     <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cmp_v_r     <= cmp_v_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r      <= op_nxt;
    name_r    <= name_nxt;
    id_r      <= id_nxt;
    found_r   <= found_nxt;
    n_r       <= n_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

endmodule

// File: src/nsr_store.sv
// nsr_store: entry memory of the service registry, one name plus id per row,
// one write port and one registered read port.
// Depends on nsr_pkg for the row width.
module nsr_store
  import nsr_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [ENTRY_W-1:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/nsr_chk.sv
// nsr_chk: port-level checks on the service registry result stream,
// bound to named_service_registry_unit.
// Depends on nsr_pkg.
module nsr_chk
  import nsr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input nsr_rsp_t out_rsp
);

  // a taken request either answers at once or keeps the block busy
  a_take_answered: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("request taken with no answer and no work");

  // snapshot beats come back to back until the last one
  a_stream_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rsp.last |=> out_valid)
    else $error("snapshot stream has a gap");

  // a request is still in flight while it has beats left to send
  a_busy_mid_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rsp.last |-> busy)
    else $error("block idle before final beat");

  a_entry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.entry_valid |-> out_rsp.status == ST_OK)
    else $error("snapshot entry with bad status");

  // any beat without an entry is a single-beat answer with no name
  a_plain_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rsp.entry_valid |-> out_rsp.last && out_rsp.out_w0 == '0 &&
      out_rsp.out_w1 == '0 && out_rsp.out_w2 == '0 && out_rsp.out_w3 == '0)
    else $error("plain result carries name data or continues");

endmodule

bind named_service_registry_unit nsr_chk u_nsr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);

// File: verif/tb_named_service_registry_unit.sv
// tb_named_service_registry_unit: self-checking bench for the service registry;
// a queue-fed driver, a result monitor and a table predictor kept in step.
// Depends on nsr_pkg and named_service_registry_unit.
module tb_named_service_registry_unit;
  import nsr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SERVICES = 32;
  localparam int POOL_SIZE    = 48;

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} mix_t;

  typedef struct {
    nsr_req_t req;
    int       gap;
    bit       drain;
  } stim_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  nsr_req_t in_req = '0;
  logic     out_valid;
  nsr_rsp_t out_rsp;

  stim_t        pending_reqs[$];
  nsr_rsp_t     expected_rsps[$];
  nsr_rsp_t     oldest_rsp;
  logic [255:0] name_pool[POOL_SIZE];

  // predicted contents of the registry table
  logic [255:0] table_name[MAX_SERVICES];
  logic [31:0]  table_id[MAX_SERVICES];
  int           table_count = 0;

  int   mismatch_count = 0;
  int   idle_count = 0;
  bit   idle_off = 1'b0;
  logic beat_taken;

  named_service_registry_unit #(
    .MAX_SERVICES(MAX_SERVICES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  always #1 clk = ~clk;

  // last byte is always dropped, everything past the first zero byte is dropped
  function automatic logic [255:0] clean_name(input nsr_req_t r);
    logic [255:0] nm;
    bit           live;
    nm = {r.name_w3, r.name_w2, r.name_w1, r.name_w0};
    nm[255:248] = 8'h00;
    live = 1'b1;
    for (int i = 0; i < 32; i++) begin
      if (!live) begin
        nm[8*i +: 8] = 8'h00;
      end else if (nm[8*i +: 8] == 8'h00) begin
        live = 1'b0;
      end
    end
    return nm;
  endfunction

  function automatic nsr_rsp_t blank_rsp();
    nsr_rsp_t rsp;
    rsp = '0;
    rsp.status = ST_OK;
    rsp.last = 1'b1;
    return rsp;
  endfunction

  task automatic record_request(input nsr_req_t r);
    logic [255:0] nm;
    nsr_rsp_t     rsp;
    int           pos;
    int           n;
    nm = clean_name(r);
    pos = -1;
    for (int i = table_count - 1; i >= 0; i--) begin
      if (table_name[i] == nm) pos = i;
    end
    rsp = blank_rsp();
    case (r.req_type)
      OP_REGISTER: begin
        if (nm[7:0] == 8'h00 || r.service_id == 32'h0 || r.service_id == 32'hFFFF_FFFF ||
            pos >= 0) begin
          rsp.status = ST_INVALID;
        end else if (table_count >= MAX_SERVICES) begin
          rsp.status = ST_NOSPACE;
        end else begin
          table_name[table_count] = nm;
          table_id[table_count] = r.service_id;
          table_count++;
        end
        rsp.entry_count = 6'(table_count);
        expected_rsps.push_back(rsp);
      end
      OP_UNREGISTER: begin
        if (nm[7:0] == 8'h00 || pos < 0) begin
          rsp.status = ST_INVALID;
        end else begin
          rsp.found_id = table_id[pos];
          for (int j = pos; j + 1 < table_count; j++) begin
            table_name[j] = table_name[j+1];
            table_id[j] = table_id[j+1];
          end
          table_count--;
        end
        rsp.entry_count = 6'(table_count);
        expected_rsps.push_back(rsp);
      end
      OP_LOOKUP: begin
        if (pos < 0) begin
          rsp.status = ST_NOTFOUND;
        end else begin
          rsp.found_id = table_id[pos];
        end
        rsp.entry_count = 6'(table_count);
        expected_rsps.push_back(rsp);
      end
      default: begin
        n = (table_count < int'(r.limit)) ? table_count : int'(r.limit);
        if (n > int'(RESULT_CAP)) n = int'(RESULT_CAP);
        rsp.entry_count = 6'(table_count);
        if (n == 0) begin
          expected_rsps.push_back(rsp);
        end else begin
          for (int k = 0; k < n; k++) begin
            rsp.found_id = table_id[k];
            {rsp.out_w3, rsp.out_w2, rsp.out_w1, rsp.out_w0} = table_name[k];
            rsp.entry_valid = 1'b1;
            rsp.last = (k == n - 1);
            expected_rsps.push_back(rsp);
          end
        end
      end
    endcase
  endtask

  task automatic check_field(input string fname, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", fname, want, got);
      mismatch_count++;
    end
  endtask

  // driver: holds start until the beat is taken, then moves to the next item
  always @(posedge clk) begin
    beat_taken = rst_n && start && !busy;
    if (beat_taken) begin
      record_request(in_req);
      void'(pending_reqs.pop_front());
      idle_count = 0;
    end
    if (rst_n && !(start && !beat_taken)) begin
      if (pending_reqs.size() != 0 && idle_count >= pending_reqs[0].gap &&
          !(pending_reqs[0].drain && expected_rsps.size() != 0)) begin
        start  <= 1'b1;
        in_req <= pending_reqs[0].req;
      end else begin
        start <= 1'b0;
        idle_count++;
      end
    end
  end

  // monitor: every result beat must match the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_rsps.size() == 0) begin
        $error("result beat with nothing expected: %p", out_rsp);
        mismatch_count++;
      end else begin
        oldest_rsp = expected_rsps.pop_front();
        check_field("status", 64'(oldest_rsp.status), 64'(out_rsp.status));
        check_field("found_id", 64'(oldest_rsp.found_id), 64'(out_rsp.found_id));
        check_field("out_w0", oldest_rsp.out_w0, out_rsp.out_w0);
        check_field("out_w1", oldest_rsp.out_w1, out_rsp.out_w1);
        check_field("out_w2", oldest_rsp.out_w2, out_rsp.out_w2);
        check_field("out_w3", oldest_rsp.out_w3, out_rsp.out_w3);
        check_field("entry_valid", 64'(oldest_rsp.entry_valid), 64'(out_rsp.entry_valid));
        check_field("entry_count", 64'(oldest_rsp.entry_count), 64'(out_rsp.entry_count));
        check_field("last", 64'(oldest_rsp.last), 64'(out_rsp.last));
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (idle_off || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [255:0] make_name(input int len);
    logic [255:0] nm;
    nm = '0;
    for (int i = 0; i < len; i++) nm[8*i +: 8] = 8'($urandom_range(1, 255));
    return nm;
  endfunction

  // junk after the terminator and in the last byte (in two of three calls), same name once cleaned
  function automatic logic [255:0] with_junk(input logic [255:0] base);
    logic [255:0] nm;
    int           p;
    nm = base;
    if ($urandom_range(0, 2) == 0) return nm;
    p = 31;
    for (int i = 30; i >= 0; i--) begin
      if (base[8*i +: 8] == 8'h00) p = i;
    end
    for (int i = p + 1; i < 32; i++) nm[8*i +: 8] = 8'($urandom);
    nm[255:248] = 8'($urandom);
    return nm;
  endfunction

  task automatic add_item(input nsr_op_t op, input logic [255:0] raw, input logic [31:0] id,
                          input logic [5:0] lim, input bit hold);
    stim_t s;
    s.req.req_type = op;
    {s.req.name_w3, s.req.name_w2, s.req.name_w1, s.req.name_w0} = raw;
    s.req.service_id = id;
    s.req.limit = lim;
    s.gap = pick_gap();
    s.drain = hold;
    pending_reqs.push_back(s);
  endtask

  task automatic add_random(input mix_t mix, input bit hold);
    int           r;
    nsr_op_t      op;
    logic [255:0] nm;
    logic [31:0]  id;
    logic [5:0]   lim;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:     op = (r < 70) ? OP_REGISTER : (r < 80) ? OP_UNREGISTER :
                         (r < 90) ? OP_LOOKUP : OP_SNAPSHOT;
      MIX_BALANCED: op = (r < 30) ? OP_REGISTER : (r < 55) ? OP_UNREGISTER :
                         (r < 85) ? OP_LOOKUP : OP_SNAPSHOT;
      default:      op = (r < 15) ? OP_REGISTER : (r < 70) ? OP_UNREGISTER :
                         (r < 90) ? OP_LOOKUP : OP_SNAPSHOT;
    endcase
    r = $urandom_range(0, 99);
    if (r < 6) nm = with_junk('0);
    else if (r < 14) nm = with_junk(make_name($urandom_range(1, 32)));
    else nm = with_junk(name_pool[$urandom_range(0, POOL_SIZE - 1)]);
    r = $urandom_range(0, 99);
    id = (r < 5) ? 32'h0 : (r < 10) ? 32'hFFFF_FFFF : 32'($urandom);
    r = $urandom_range(0, 99);
    lim = (r < 15) ? 6'($urandom_range(33, 63)) : (r < 35) ? 6'd32 :
          6'($urandom_range(0, 31));
    add_item(op, nm, id, lim, hold);
  endtask

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [255:0] name_a;
    logic [255:0] name_b;
    logic [255:0] name_c;
    logic [255:0] all_set;
    mix_t         mix;

    for (int i = 0; i < POOL_SIZE; i++) begin
      name_pool[i] = make_name(($urandom_range(0, 3) == 0) ? $urandom_range(9, 32) :
                                                             $urandom_range(1, 8));
    end
    name_a  = make_name(32);
    name_b  = make_name(5);
    name_c  = make_name(1);
    all_set = '1;

    // directed: empty table, bad registers, duplicates, snapshot edges, shifting
    add_item(OP_SNAPSHOT, '0, 32'h0, 6'd5, 1'b0);
    add_item(OP_LOOKUP, name_a, 32'h0, 6'd0, 1'b0);
    add_item(OP_UNREGISTER, name_a, 32'h0, 6'd0, 1'b0);
    add_item(OP_REGISTER, with_junk('0), 32'h1234, 6'd0, 1'b0);
    add_item(OP_REGISTER, name_a, 32'h0, 6'd0, 1'b0);
    add_item(OP_REGISTER, name_a, 32'hFFFF_FFFF, 6'd0, 1'b0);
    add_item(OP_REGISTER, with_junk(name_a), 32'h1, 6'd0, 1'b0);
    add_item(OP_REGISTER, with_junk(name_a), 32'h7, 6'd0, 1'b0);
    add_item(OP_REGISTER, with_junk(name_b), 32'hFFFF_FFFE, 6'd0, 1'b0);
    add_item(OP_REGISTER, name_c, 32'h8000_0000, 6'd0, 1'b0);
    add_item(OP_REGISTER, all_set, 32'h5A5A_A5A5, 6'd63, 1'b0);
    add_item(OP_LOOKUP, with_junk(name_b), 32'h0, 6'd0, 1'b0);
    add_item(OP_LOOKUP, with_junk('0), 32'h0, 6'd0, 1'b0);
    add_item(OP_SNAPSHOT, '0, 32'h0, 6'd0, 1'b0);
    add_item(OP_SNAPSHOT, all_set, 32'hFFFF_FFFF, 6'd2, 1'b0);
    add_item(OP_SNAPSHOT, '0, 32'h0, 6'd63, 1'b0);
    add_item(OP_UNREGISTER, with_junk(name_a), 32'h0, 6'd0, 1'b1);
    add_item(OP_UNREGISTER, with_junk('0), 32'h0, 6'd0, 1'b0);
    add_item(OP_UNREGISTER, name_a, 32'h0, 6'd0, 1'b0);
    add_item(OP_LOOKUP, name_c, 32'h0, 6'd0, 1'b0);
    add_item(OP_UNREGISTER, all_set, 32'h0, 6'd0, 1'b0);
    add_item(OP_SNAPSHOT, '0, 32'h0, 6'd32, 1'b0);

    // random blocks: fill past capacity, churn, drain; two blocks run back to back
    for (int blk = 0; blk < 6; blk++) begin
      mix = (blk % 3 == 0) ? MIX_FILL : (blk % 3 == 1) ? MIX_BALANCED : MIX_DRAIN;
      idle_off = (blk == 1 || blk == 3);
      for (int i = 0; i < 50; i++) begin
        add_random(mix, i == 0 || $urandom_range(0, 49) == 0);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
src/nsr_pkg.sv
src/nsr_store.sv
src/named_service_registry_unit.sv
src/nsr_chk.sv
verif/tb_named_service_registry_unit.sv
